### hw/rtl/ewh_pkg.sv
// ----------------------------------------------------------------------------
// ewh_pkg: shared types and constants for the equal-width histogram
// Holds field widths, the sequencer state type and the count limit and fixed-point constants.
// ----------------------------------------------------------------------------
package ewh_pkg;
  localparam int SampleW = 31;
  localparam int StartW  = 32;
  localparam int TotalW  = 11;
  localparam int IndexW  = 6;
  localparam int BinCfgW = 7;
  localparam logic [TotalW-1:0] CountMax = 11'd2047;
  localparam logic signed [33:0] HalfQ16 = 34'sd32768;
  localparam logic [17:0] OneQ16 = 18'd65536;

  typedef enum logic [8:0] {
    ST_LOAD  = 9'b0_0000_0001,
    ST_DIV   = 9'b0_0000_0010,
    ST_CLEAR = 9'b0_0000_0100,
    ST_RDREQ = 9'b0_0000_1000,
    ST_SCAN  = 9'b0_0001_0000,
    ST_BUMP  = 9'b0_0010_0000,
    ST_COUNT = 9'b0_0100_0000,
    ST_EMIT  = 9'b0_1000_0000,
    ST_HOLD  = 9'b1_0000_0000
  } ewh_state_t;
endpackage

### hw/rtl/ewh_if.sv
// ----------------------------------------------------------------------------
// ewh_in_if / ewh_out_if / ewh_cfg_if: valid-ready channels
// Input samples, per-bin results and the bin count register write.
// ----------------------------------------------------------------------------
interface ewh_in_if;
  logic valid;
  logic ready;
  logic signed [30:0] sample;
  logic last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface ewh_out_if;
  logic valid;
  logic ready;
  logic [5:0] bin_index;
  logic signed [31:0] bin_start;
  logic [10:0] bin_total;
  logic overflowed;
  logic last_bin;
  modport source (output valid, bin_index, bin_start, bin_total, overflowed, last_bin,
                  input ready);
  modport sink (input valid, bin_index, bin_start, bin_total, overflowed, last_bin,
                output ready);
endinterface

interface ewh_cfg_if;
  logic valid;
  logic ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/ewh_ram.sv
// ----------------------------------------------------------------------------
// ewh_ram: generic simple dual-port RAM with registered read
// One write address and one read address per cycle.
// ----------------------------------------------------------------------------
module ewh_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/ewh_div.sv
// ----------------------------------------------------------------------------
// ewh_div: restoring divider, one quotient bit per cycle
// Floor division of a signed 33-bit dividend by a positive 7-bit divisor.
// ----------------------------------------------------------------------------
module ewh_div
  import ewh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] dividend,
  input  logic [6:0]         divisor,
  output logic               done,
  output logic signed [32:0] quotient
);
  logic [32:0] mag;
  logic [32:0] quo;
  logic [7:0]  rem;
  logic        neg;
  logic [5:0]  step;
  logic        busy;
  logic [7:0]  trial;
  logic [7:0]  rem_next;

  always_comb begin
    trial = {rem[6:0], mag[32]};
    rem_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'd0;
        neg  <= dividend[32];
        mag  <= dividend[32] ? 33'(-dividend) : 33'(dividend);
        rem  <= 8'd0;
        quo  <= 33'd0;
      end else if (busy) begin
        mag  <= {mag[31:0], 1'b0};
        rem  <= rem_next;
        quo  <= {quo[31:0], trial >= {1'b0, divisor}};
        step <= step + 6'd1;
        if (step == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
          // Floor for negative dividends: round toward minus infinity.
          if (neg) begin
            quotient <= -$signed({quo[31:0], trial >= {1'b0, divisor}})
                        - ((rem_next != 8'd0) ? 33'sd1 : 33'sd0);
          end else begin
            quotient <= $signed({quo[31:0], trial >= {1'b0, divisor}});
          end
        end
      end
    end
  end
endmodule

### hw/rtl/equal_width_histogram.sv
// ----------------------------------------------------------------------------
// equal_width_histogram: equal-width binning of a sorted Q15.16 sample set
// Samples are stored while loading. After the last sample the block divides
// the range to get the increment, clears B counts, primes the scan and, in a
// single start/compare unit, tests each sample against the bin edges in turn
// (the maximum of a spread set goes to the top bin), then emits B words. No
// new sample is taken until the last word of the set is accepted.
// Reset: synchronous, active high; bin count to 10, sample total to zero.
// ----------------------------------------------------------------------------
module equal_width_histogram
  import ewh_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_BINS    = 64
) (
  input logic clk,
  input logic rst,
  ewh_in_if.sink    in_ch,
  ewh_out_if.source out_ch,
  ewh_cfg_if.sink   cfg
);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  ewh_state_t state;
  logic [BinCfgW-1:0] bin_cfg;
  logic [CW-1:0]      total;
  logic [AW-1:0]      rd_idx;
  logic [CW-1:0]      scan_i;
  logic               drop;
  logic signed [SampleW-1:0] first_value;
  logic signed [SampleW-1:0] last_value;
  logic signed [33:0] start_base;
  logic signed [33:0] inc;
  logic signed [33:0] edge_lo;
  logic               degen;
  logic [6:0]         nb;
  logic [BW-1:0]      j;
  logic [BW-1:0]      target;
  logic signed [SampleW-1:0] cur;
  logic               div_start;
  logic               div_done;
  logic signed [32:0] div_q;
  logic signed [SampleW-1:0] rd_data;
  logic               accept;
  logic [6:0]         bin_clip;
  logic               cnt_we;
  logic [BW-1:0]      cnt_waddr;
  logic [TotalW-1:0]  cnt_wdata;
  logic [BW-1:0]      cnt_raddr;
  logic [TotalW-1:0]  cnt_rdata;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_LOAD);
  assign cfg.ready = 1'b1;

  // Clip the bin count to 1..MAX_BINS.
  always_comb begin
    if (bin_cfg == 7'd0) begin
      bin_clip = 7'd1;
    end else if (bin_cfg > 7'(MAX_BINS)) begin
      bin_clip = 7'(MAX_BINS);
    end else begin
      bin_clip = bin_cfg;
    end
  end

  ewh_ram #(.WIDTH(SampleW), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (accept && (total < CW'(MAX_SAMPLES))),
    .waddr (total[AW-1:0]),
    .wdata (in_ch.sample),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // Bin counts live in a small RAM. The clearing pass writes zeros; after a
  // sample is classified its bin is read on the last compare cycle and the
  // saturated increment is written back in ST_COUNT. While results go out the
  // read address follows the bin being reported.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = target;
    cnt_wdata = (cnt_rdata == CountMax) ? cnt_rdata : cnt_rdata + TotalW'(1);
    cnt_raddr = j;
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = j;
      cnt_wdata = '0;
    end else if (state == ST_COUNT) begin
      cnt_we = 1'b1;
    end
    if (state == ST_BUMP || state == ST_COUNT) begin
      cnt_raddr = target;
    end
  end

  ewh_ram #(.WIDTH(TotalW), .DEPTH(MAX_BINS)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // The count of the reported bin is read in ST_EMIT and stays put
  // while the word waits in ST_HOLD.
  assign out_ch.bin_total = cnt_rdata;

  // Range numerator is max-min, or one unit when the set is flat.
  logic signed [32:0] div_num;
  assign div_num = degen ? $signed(33'(OneQ16)) : (33'(last_value) - 33'(first_value));

  ewh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (nb),
    .done     (div_done),
    .quotient (div_q)
  );

  // The shared compare unit: one bin edge a cycle against the current sample.
  logic signed [33:0] edge_hi;
  logic               hit;
  assign edge_hi = edge_lo + inc;
  assign hit = (34'(cur) >= edge_lo) && (34'(cur) < edge_hi);

  logic is_last_sample;
  assign is_last_sample = (scan_i == total - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      bin_cfg <= 7'd10;
      total   <= '0;
      drop    <= 1'b0;
      div_start <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg.valid) begin
        bin_cfg <= cfg.data;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (total < CW'(MAX_SAMPLES)) begin
              if (total == '0) begin
                first_value <= in_ch.sample;
                degen <= 1'b1;
              end else begin
                degen <= (in_ch.sample == first_value);
              end
              last_value <= in_ch.sample;
              total <= total + CW'(1);
            end else begin
              drop <= 1'b1;
            end
            if (in_ch.last_sample) begin
              nb <= bin_clip;
              div_start <= 1'b1;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          j <= '0;
          if (div_done) begin
            inc <= 34'(div_q);
            start_base <= degen ? (34'(first_value) - HalfQ16) : 34'(first_value);
            state <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (7'(j) == nb - 7'd1) begin
            scan_i <= '0;
            rd_idx <= '0;
            state <= ST_RDREQ;
          end else begin
            j <= j + BW'(1);
          end
        end
        ST_RDREQ: begin
          // Read data appears next cycle.
          j <= '0;
          edge_lo <= start_base;
          target <= BW'(nb - 7'd1);
          state <= ST_SCAN;
          rd_idx <= rd_idx + AW'(1);
        end
        ST_SCAN: begin
          // The first sample of the scan is taken from the store here.
          cur <= rd_data;
          state <= ST_BUMP;
        end
        ST_BUMP: begin
          if (7'(j) + 7'd1 < nb && !(is_last_sample && !degen)) begin
            if (hit) begin
              target <= j;
            end
            j <= j + BW'(1);
            edge_lo <= edge_hi;
          end else begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (is_last_sample) begin
            j <= '0;
            edge_lo <= start_base;
            state <= ST_EMIT;
          end else begin
            scan_i <= scan_i + CW'(1);
            j <= '0;
            edge_lo <= start_base;
            target <= BW'(nb - 7'd1);
            cur <= rd_data;
            rd_idx <= rd_idx + AW'(1);
            state <= ST_BUMP;
          end
        end
        ST_EMIT: begin
          out_ch.valid      <= 1'b1;
          out_ch.bin_index  <= 6'(j);
          out_ch.bin_start  <= edge_lo[31:0];
          out_ch.overflowed <= drop;
          out_ch.last_bin   <= (7'(j) == nb - 7'd1);
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.last_bin) begin
              total <= '0;
              drop  <= 1'b0;
              state <= ST_LOAD;
            end else begin
              j <= j + BW'(1);
              edge_lo <= edge_hi;
              state <= ST_EMIT;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ST_LOAD) else $error("ready outside load");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_SAMPLES)) else $error("sample total beyond capacity");
  a_valid_emit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == ST_HOLD) else $error("result outside hold");
  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_bin) |=> total == '0)
    else $error("set not closed");
endmodule

### tb/equal_width_histogram_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_width_histogram_test: self-checking bench for the equal-width histogram
// Sends sample sets through the input channel, computes the expected per-bin
// starts and totals, and compares every result word against them in order.
// ----------------------------------------------------------------------------
module equal_width_histogram_test
  import ewh_pkg::*;
();

  localparam int SampleCap = 1024;
  localparam int BinCap    = 64;
  localparam int SampleLo  = -(2 ** 30);
  localparam int SampleHi  = 2 ** 30 - 1;

  // One expected result word: a single bin of a closed set.
  typedef struct {
    logic [IndexW-1:0]        index;
    logic signed [StartW-1:0] start;
    logic [TotalW-1:0]        total;
    logic                     dropped;
    logic                     final_bin;
  } bin_report_t;

  logic clk;
  logic rst;

  ewh_in_if  in_ch ();
  ewh_out_if out_ch ();
  ewh_cfg_if cfg ();

  equal_width_histogram dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Shadow state of the histogram: samples of the open set, the dropped
  // flag and the bin count register.
  longint      set_samples[$];
  bit          set_dropped;
  int unsigned bin_setting = 10;

  bin_report_t pending_bins[$];
  int          fail_count;
  bit          calm;  // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous upper bound on the whole run.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Floor division as the block does it: rounds towards minus infinity.
  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // Closes the shadow set: classifies every stored sample and queues one
  // expected word per bin, then empties the set.
  function automatic void close_set();
    int unsigned nb;
    int unsigned n;
    int unsigned target;
    longint      lo, hi, inc, first_start, a;
    bit          flat;
    int unsigned counts[BinCap];
    bin_report_t rep;
    nb = bin_setting;
    if (nb < 1) nb = 1;
    if (nb > BinCap) nb = BinCap;
    n  = set_samples.size();
    lo = set_samples[0];
    hi = set_samples[n-1];
    flat = (lo == hi);
    // A set with a single value gets bins of width 1.0/B centred on it.
    if (flat) begin
      inc = floor_quot(65536, nb);
      first_start = lo - 32768;
    end else begin
      inc = floor_quot(hi - lo, nb);
      first_start = lo;
    end
    foreach (counts[j]) counts[j] = 0;
    for (int i = 0; i < n; i++) begin
      target = nb - 1;
      // In the normal case the maximum is forced into the top bin.
      if (flat || i != n - 1) begin
        for (int j = 0; j + 1 < nb; j++) begin
          a = first_start + longint'(j) * inc;
          if (set_samples[i] >= a && set_samples[i] < a + inc) target = j;
        end
      end
      if (counts[target] < CountMax) counts[target]++;
    end
    for (int j = 0; j < nb; j++) begin
      rep.index     = IndexW'(j);
      rep.start     = StartW'(first_start + longint'(j) * inc);
      rep.total     = TotalW'(counts[j]);
      rep.dropped   = set_dropped;
      rep.final_bin = (j == nb - 1);
      pending_bins.push_back(rep);
    end
    set_samples.delete();
    set_dropped = 1'b0;
  endfunction

  // Sends one word on the input channel; called at a rising edge.
  task automatic send_sample(longint value, bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= value[SampleW-1:0];
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (set_samples.size() < SampleCap) set_samples.push_back(value);
    else set_dropped = 1'b1;
    if (last) close_set();
  endtask

  // Waits for the block to go idle, then writes the bin count register.
  task automatic write_bins(int unsigned value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value[BinCfgW-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    bin_setting = value;
  endtask

  task automatic send_set(longint values[$]);
    foreach (values[i]) send_sample(values[i], i == values.size() - 1);
  endtask

  // Random sample anywhere in the signed 31-bit range.
  function automatic longint any_sample();
    logic signed [SampleW-1:0] r;
    r = SampleW'($urandom);
    return longint'(r);
  endfunction

  // Output side: stalls in random bursts unless the run is in its calm part.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Each accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin
    bin_report_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_bins.size() == 0) begin
        $error("result word for bin %0d arrived with none expected", out_ch.bin_index);
        fail_count++;
      end else begin
        want = pending_bins.pop_front();
        if (out_ch.bin_index !== want.index) begin
          $error("bin_index: expected %0d, got %0d", want.index, out_ch.bin_index);
          fail_count++;
        end
        if (out_ch.bin_start !== want.start) begin
          $error("bin_start: expected %0d, got %0d", want.start, out_ch.bin_start);
          fail_count++;
        end
        if (out_ch.bin_total !== want.total) begin
          $error("bin_total: expected %0d, got %0d", want.total, out_ch.bin_total);
          fail_count++;
        end
        if (out_ch.overflowed !== want.dropped) begin
          $error("overflowed: expected %0b, got %0b", want.dropped, out_ch.overflowed);
          fail_count++;
        end
        if (out_ch.last_bin !== want.final_bin) begin
          $error("last_bin: expected %0b, got %0b", want.final_bin, out_ch.last_bin);
          fail_count++;
        end
      end
    end
  end

  // Both ends of the range in one set, with the bin count above its limit.
  task automatic test_extremes();
    write_bins(127);
    send_set('{SampleLo, -1, 0, 1, SampleHi});
    write_bins(64);
    send_set('{SampleLo, SampleHi});
  endtask

  // A single sample, and a set of equal samples: bins of width 1.0/B.
  task automatic test_flat_sets();
    write_bins(0);
    send_set('{12345});
    write_bins(3);
    send_set('{SampleHi, SampleHi, SampleHi});
    send_set('{SampleLo});
  endtask

  // Spread smaller than the bin count, so every start is the same.
  task automatic test_zero_increment();
    write_bins(10);
    send_set('{100, 101, 102, 103});
  endtask

  // Descending input gives a negative increment.
  task automatic test_unsorted();
    write_bins(5);
    send_set('{500000, 20, -300000, -700000});
  endtask

  // More samples than the store holds; the extra ones, the last too, drop.
  task automatic test_store_full();
    longint vals[$];
    write_bins(2);
    for (int i = 0; i < SampleCap + 2; i++) vals.push_back(longint'(i) * 1000 - 400000);
    send_set(vals);
  endtask

  // Random sets, mostly sorted with random spread, some flat or shuffled.
  task automatic test_random_sets(int item_goal);
    longint vals[$];
    longint base;
    int     sent, n, kind, spread;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: write_bins(1);
          1: write_bins(64);
          2: write_bins($urandom_range(65, 127));
          default: write_bins($urandom_range(1, 20));
        endcase
      end
      if (sent > item_goal * 3 / 4) calm = 1'b1;
      vals.delete();
      n = $urandom_range(1, 12);
      kind = $urandom_range(0, 9);
      spread = ($urandom_range(0, 1) != 0) ? 200 : 65536 * 8;
      base = any_sample();
      if (base > SampleHi - spread) base = SampleHi - spread;
      for (int i = 0; i < n; i++) begin
        if (kind < 3) vals.push_back(any_sample());
        else if (kind == 9) vals.push_back(base);
        else vals.push_back(base + $urandom_range(0, spread));
      end
      if (kind != 0) vals.sort();
      send_set(vals);
      sent += n;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last_sample <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    calm = 1'b0;
    fail_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_flat_sets();
    test_zero_increment();
    test_unsorted();
    test_store_full();
    test_random_sets(360);

    calm = 1'b1;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_bins.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/ewh_pkg.sv
hw/rtl/ewh_if.sv
hw/rtl/ewh_ram.sv
hw/rtl/ewh_div.sv
hw/rtl/equal_width_histogram.sv
tb/equal_width_histogram_test.sv
